// ===== hw/rtl/etc_pkg.sv =====
// Shared types, constants and the exponential table for the transition energy correction.
package etc_pkg;

   localparam int ENERGY_WIDTH    = 32;
   localparam int EXP_TABLE_BITS  = 8;
   localparam int TABLE_SIZE      = (1 << EXP_TABLE_BITS) + 1;
   localparam int IDX_WIDTH       = EXP_TABLE_BITS + 1;
   localparam int FRAC_SHIFT      = 12 - EXP_TABLE_BITS;
   localparam int EXP_ENTRY_WIDTH = 18;
   localparam int NUM_LAYERS      = 6;
   localparam int NUM_ENERGIES    = NUM_LAYERS + 1;
   localparam int ETA_WIDTH       = 16;
   localparam int COEF_WIDTH      = 16;
   localparam int FACTOR_WIDTH    = 16;
   localparam int Q14_SHIFT       = 14;
   localparam int EDIV_BITS       = ENERGY_WIDTH + Q14_SHIFT;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 64;

   localparam logic [FACTOR_WIDTH-1:0] ONE_Q14   = 16'd16384;
   localparam logic [12:0]             LOG2E_Q12 = 13'd5909;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_USE_ADJUSTED_ETA    = 3'd0,
      CSR_ZERO_WINDOW         = 3'd1,
      CSR_EIGHT_WINDOW        = 3'd2,
      CSR_ZERO_COEFFS_FIRST   = 3'd3,
      CSR_ZERO_COEFFS_SECOND  = 3'd4,
      CSR_EIGHT_COEFFS_FIRST  = 3'd5,
      CSR_EIGHT_COEFFS_SECOND = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      MODE_ONE,
      MODE_PLATEAU,
      MODE_SHAPE
   } mode_type;

   typedef struct packed {
      logic        use_adjusted_eta;
      logic [31:0] zero_window;
      logic [31:0] eight_window;
      logic [63:0] zero_coeffs_first;
      logic [47:0] zero_coeffs_second;
      logic [63:0] eight_coeffs_first;
      logic [31:0] eight_coeffs_second;
   } cfg_type;

   // energy[0] is the total, then the layers in mask order
   typedef struct packed {
      logic [NUM_ENERGIES-1:0][ENERGY_WIDTH-1:0] energy;
      logic [NUM_LAYERS-1:0]                     mask;
   } payload_type;

   typedef struct packed {
      logic [FACTOR_WIDTH-1:0] factor;
      logic                    applied;
      logic                    nonpos;
      logic                    sat;
   } factor_type;

   typedef logic [EXP_ENTRY_WIDTH-1:0] exp_table_type [TABLE_SIZE];

   // 2^(i/2^B) in Q16, from a thirteen-term Q30 Taylor sum of exp(i*ln2/2^B)
   function automatic exp_table_type build_exp_table();
      exp_table_type t;
      logic [63:0]   u;
      logic [63:0]   term;
      logic [63:0]   sum;
      for (int i = 0; i < TABLE_SIZE; i++) begin
         u    = (64'(i) * 64'd744261118) >> EXP_TABLE_BITS;
         term = 64'd1 << 30;
         sum  = term;
         for (int k = 1; k <= 12; k++) begin
            term = ((term * u) >> 30) / 64'(k);
            sum  = sum + term;
         end
         t[i] = EXP_ENTRY_WIDTH'((sum + 64'd8192) >> 14);
      end
      return t;
   endfunction

   localparam exp_table_type EXP_TABLE = build_exp_table();

endpackage

// ===== hw/rtl/etc_factor.sv =====
// Pipelined correction factor: |eta|, window select, two exponentials, pipelined divide.
module etc_factor (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       in_valid,
   input  logic signed [etc_pkg::ETA_WIDTH-1:0]       in_raw_eta,
   input  logic signed [etc_pkg::ETA_WIDTH-1:0]       in_adjusted_eta,
   input  etc_pkg::payload_type                       in_payload,
   input  etc_pkg::cfg_type                           cfg,
   output logic                                       out_valid,
   output etc_pkg::payload_type                       out_payload,
   output etc_pkg::factor_type                        out_factor
);

   localparam int A_WIDTH    = etc_pkg::ETA_WIDTH + 1;
   localparam int X_WIDTH    = 19;
   localparam int PROD_WIDTH = 35;
   localparam int XE_WIDTH   = 25;
   localparam int Y_WIDTH    = 39;
   localparam int N_WIDTH    = 15;
   localparam int EXP_WIDTH  = 42;
   localparam int D_WIDTH    = 44;
   localparam int QB         = 36;
   localparam int Q_WIDTH    = 38;
   localparam int RAW_WIDTH  = 39;
   localparam int EW         = etc_pkg::EXP_ENTRY_WIDTH;

   typedef struct packed {
      logic signed [15:0]   c0;
      logic signed [15:0]   c1;
      logic signed [15:0]   c5;
      logic signed [15:0]   c6;
      etc_pkg::mode_type    mode;
      etc_pkg::payload_type payload;
   } carry_type;

   typedef struct packed {
      logic [QB-1:0]        num;
      logic [D_WIDTH-1:0]   rem;
      logic [QB-1:0]        quo;
      logic [D_WIDTH-1:0]   divisor;
      logic                 qneg;
      logic                 dzero;
      logic                 c1neg;
      logic                 c1zero;
      logic signed [15:0]   c0;
      logic signed [15:0]   c6;
      etc_pkg::mode_type    mode;
      etc_pkg::payload_type payload;
   } div_type;

   function automatic div_type div_step(input div_type s);
      div_type             r;
      logic [D_WIDTH:0]    rem2;
      logic                ge;
      r    = s;
      rem2 = {s.rem, s.num[QB-1]};
      ge   = (rem2 >= {1'b0, s.divisor});
      r.rem = ge ? D_WIDTH'(rem2 - {1'b0, s.divisor}) : rem2[D_WIDTH-1:0];
      r.num = {s.num[QB-2:0], 1'b0};
      r.quo = {s.quo[QB-2:0], ge};
      return r;
   endfunction

   // stage 1: |eta|
   logic                          v1_ff;
   logic [A_WIDTH-1:0]            a1_ff, a1_in;
   etc_pkg::payload_type          p1_ff;
   logic signed [etc_pkg::ETA_WIDTH-1:0] eta_sel;
   logic signed [A_WIDTH-1:0]     eta_ext;

   always_comb begin
      eta_sel = cfg.use_adjusted_eta ? in_adjusted_eta : in_raw_eta;
      eta_ext = {eta_sel[etc_pkg::ETA_WIDTH-1], eta_sel};
      a1_in   = eta_sel[etc_pkg::ETA_WIDTH-1] ? A_WIDTH'(-eta_ext) : A_WIDTH'(eta_ext);
   end

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else       v1_ff <= in_valid;
   end
   always_ff @(posedge clock) begin
      a1_ff <= a1_in;
      p1_ff <= in_payload;
   end

   // stage 2: window decision, coefficient select, exponent arguments
   logic                       v2_ff;
   carry_type                  k2_ff, k2_in;
   logic signed [X_WIDTH-1:0]  x1_2_ff, x1_2_in, diff2_ff, diff2_in;
   logic signed [15:0]         c3_2_ff, c3_2_in;
   logic [A_WIDTH-1:0]         zlo, zhi, elo, ehi;
   logic                       hit8, hitz, below;
   logic [63:0]                first;
   logic [31:0]                second;
   logic signed [15:0]         c2, c4;
   logic signed [X_WIDTH-1:0]  a_s;

   always_comb begin
      zlo   = {1'b0, cfg.zero_window[15:0]};
      zhi   = {1'b0, cfg.zero_window[31:16]};
      elo   = {1'b0, cfg.eight_window[15:0]};
      ehi   = {1'b0, cfg.eight_window[31:16]};
      hit8  = (a1_ff < ehi) && (a1_ff > elo);
      hitz  = (a1_ff < zhi) && (a1_ff > zlo);
      below = (a1_ff < zlo);
      first  = hit8 ? cfg.eight_coeffs_first : cfg.zero_coeffs_first;
      second = hit8 ? cfg.eight_coeffs_second : cfg.zero_coeffs_second[31:0];
      c2 = first[47:32];
      c4 = second[15:0];
      a_s = $signed({2'b00, a1_ff});
      x1_2_in  = $signed({c2[15], c2, 2'b00}) - a_s;
      diff2_in = a_s - $signed({c4[15], c4, 2'b00});
      c3_2_in  = first[63:48];
      k2_in.c0 = first[15:0];
      k2_in.c1 = first[31:16];
      k2_in.c5 = second[31:16];
      k2_in.c6 = cfg.zero_coeffs_second[47:32];
      k2_in.payload = p1_ff;
      priority if (hit8 || hitz) k2_in.mode = etc_pkg::MODE_SHAPE;
      else if (below)            k2_in.mode = etc_pkg::MODE_PLATEAU;
      else                       k2_in.mode = etc_pkg::MODE_ONE;
   end

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else       v2_ff <= v1_ff;
   end
   always_ff @(posedge clock) begin
      k2_ff    <= k2_in;
      x1_2_ff  <= x1_2_in;
      diff2_ff <= diff2_in;
      c3_2_ff  <= c3_2_in;
   end

   // stage 3: c3 * (a - 4*c4)
   logic                         v3_ff;
   carry_type                    k3_ff;
   logic signed [X_WIDTH-1:0]    x1_3_ff;
   logic signed [PROD_WIDTH-1:0] prod3_ff, prod3_in;

   assign prod3_in = c3_2_ff * diff2_ff;

   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else       v3_ff <= v2_ff;
   end
   always_ff @(posedge clock) begin
      k3_ff    <= k2_ff;
      x1_3_ff  <= x1_2_ff;
      prod3_ff <= prod3_in;
   end

   // stage 4: scale both arguments by log2(e)
   logic                        v4_ff;
   carry_type                   k4_ff;
   logic signed [Y_WIDTH-1:0]   y4_ff [2];
   logic signed [Y_WIDTH-1:0]   y4_in [2];
   logic signed [XE_WIDTH-1:0]  xe [2];
   logic signed [13:0]          log2e_s;

   always_comb begin
      log2e_s = $signed({1'b0, etc_pkg::LOG2E_Q12});
      xe[0] = {{(XE_WIDTH-X_WIDTH){x1_3_ff[X_WIDTH-1]}}, x1_3_ff};
      xe[1] = prod3_ff[PROD_WIDTH-1:10];
      for (int j = 0; j < 2; j++) begin
         y4_in[j] = xe[j] * log2e_s;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else       v4_ff <= v3_ff;
   end
   always_ff @(posedge clock) begin
      k4_ff <= k3_ff;
      for (int j = 0; j < 2; j++) y4_ff[j] <= y4_in[j];
   end

   // stage 5: split exponent, table read
   logic                          v5_ff;
   carry_type                     k5_ff;
   logic signed [N_WIDTH-1:0]     n5_ff [2];
   logic [EW-1:0]                 lo5_ff [2];
   logic [EW-1:0]                 hi5_ff [2];
   logic [11:0]                   rem5_ff [2];
   logic [11:0]                   fr [2];
   logic [etc_pkg::IDX_WIDTH-1:0] idx [2];

   always_comb begin
      for (int j = 0; j < 2; j++) begin
         fr[j]  = y4_ff[j][23:12];
         idx[j] = etc_pkg::IDX_WIDTH'(fr[j] >> etc_pkg::FRAC_SHIFT);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v5_ff <= 1'b0;
      else       v5_ff <= v4_ff;
   end
   always_ff @(posedge clock) begin
      k5_ff <= k4_ff;
      for (int j = 0; j < 2; j++) begin
         n5_ff[j]   <= y4_ff[j][Y_WIDTH-1:24];
         lo5_ff[j]  <= etc_pkg::EXP_TABLE[idx[j]];
         hi5_ff[j]  <= etc_pkg::EXP_TABLE[etc_pkg::IDX_WIDTH'(idx[j] + 1'b1)];
         rem5_ff[j] <= fr[j] & 12'((1 << etc_pkg::FRAC_SHIFT) - 1);
      end
   end

   // stage 6: linear interpolation
   logic                      v6_ff;
   carry_type                 k6_ff;
   logic signed [N_WIDTH-1:0] n6_ff [2];
   logic [EW-1:0]             m6_ff [2];
   logic [EW-1:0]             m6_in [2];
   logic [EW+11:0]            slope [2];

   always_comb begin
      for (int j = 0; j < 2; j++) begin
         slope[j] = {12'd0, EW'(hi5_ff[j] - lo5_ff[j])} * {{EW{1'b0}}, rem5_ff[j]};
         m6_in[j] = lo5_ff[j] + EW'(slope[j] >> etc_pkg::FRAC_SHIFT);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v6_ff <= 1'b0;
      else       v6_ff <= v5_ff;
   end
   always_ff @(posedge clock) begin
      k6_ff <= k5_ff;
      for (int j = 0; j < 2; j++) begin
         n6_ff[j] <= n5_ff[j];
         m6_ff[j] <= m6_in[j];
      end
   end

   // stage 7: scale by 2^n with overflow and underflow limits
   logic                      v7_ff;
   carry_type                 k7_ff;
   logic [EXP_WIDTH-1:0]      e7_ff [2];
   logic [EXP_WIDTH-1:0]      e7_in [2];
   logic [N_WIDTH-1:0]        nneg [2];

   always_comb begin
      for (int j = 0; j < 2; j++) begin
         nneg[j] = N_WIDTH'(-n6_ff[j]);
         priority if (n6_ff[j] > 15'sd23)  e7_in[j] = EXP_WIDTH'(1) << 40;
         else if (n6_ff[j] < -15'sd20)     e7_in[j] = '0;
         else if (!n6_ff[j][N_WIDTH-1])    e7_in[j] = EXP_WIDTH'(m6_ff[j]) << n6_ff[j][4:0];
         else                              e7_in[j] = EXP_WIDTH'(m6_ff[j]) >> nneg[j][4:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v7_ff <= 1'b0;
      else       v7_ff <= v6_ff;
   end
   always_ff @(posedge clock) begin
      k7_ff <= k6_ff;
      for (int j = 0; j < 2; j++) e7_ff[j] <= e7_in[j];
   end

   // stage 8: denominator
   logic                       v8_ff;
   carry_type                  k8_ff;
   logic signed [D_WIDTH-1:0]  d8_ff, d8_in;

   assign d8_in = $signed({2'b00, e7_ff[0]}) + $signed({2'b00, e7_ff[1]})
                + $signed({{22{k7_ff.c5[15]}}, k7_ff.c5, 6'b000000});

   always_ff @(posedge clock) begin
      if (reset) v8_ff <= 1'b0;
      else       v8_ff <= v7_ff;
   end
   always_ff @(posedge clock) begin
      k8_ff <= k7_ff;
      d8_ff <= d8_in;
   end

   // divider: setup stage then one quotient bit per stage
   logic    dv_valid_ff [QB+1];
   div_type dv_ff [QB+1];
   div_type dv_in;
   logic [15:0] c1mag;

   always_comb begin
      c1mag         = k8_ff.c1[15] ? 16'(-k8_ff.c1) : 16'(k8_ff.c1);
      dv_in.num     = {c1mag, 20'd0};
      dv_in.rem     = '0;
      dv_in.quo     = '0;
      dv_in.divisor = d8_ff[D_WIDTH-1] ? D_WIDTH'(-d8_ff) : D_WIDTH'(d8_ff);
      dv_in.qneg    = k8_ff.c1[15] ^ d8_ff[D_WIDTH-1];
      dv_in.dzero   = (d8_ff == '0);
      dv_in.c1neg   = k8_ff.c1[15];
      dv_in.c1zero  = (k8_ff.c1 == '0);
      dv_in.c0      = k8_ff.c0;
      dv_in.c6      = k8_ff.c6;
      dv_in.mode    = k8_ff.mode;
      dv_in.payload = k8_ff.payload;
   end

   always_ff @(posedge clock) begin
      if (reset) dv_valid_ff[0] <= 1'b0;
      else       dv_valid_ff[0] <= v8_ff;
   end
   always_ff @(posedge clock) begin
      dv_ff[0] <= dv_in;
   end

   for (genvar s = 1; s <= QB; s++) begin : g_div
      always_ff @(posedge clock) begin
         if (reset) dv_valid_ff[s] <= 1'b0;
         else       dv_valid_ff[s] <= dv_valid_ff[s-1];
      end
      always_ff @(posedge clock) begin
         dv_ff[s] <= div_step(dv_ff[s-1]);
      end
   end

   // final: factor assembly and clamp
   logic                        out_valid_ff;
   etc_pkg::payload_type        out_payload_ff;
   etc_pkg::factor_type         out_factor_ff, fac_in;
   logic signed [Q_WIDTH-1:0]   q;
   logic signed [RAW_WIDTH-1:0] raw;
   div_type                     fin;

   always_comb begin
      fin = dv_ff[QB];
      if (fin.dzero) begin
         if (fin.c1zero)     q = '0;
         else if (fin.c1neg) q = -(Q_WIDTH'(1) <<< 36);
         else                q = Q_WIDTH'(1) <<< 36;
      end else begin
         q = fin.qneg ? -$signed({2'b00, fin.quo}) : $signed({2'b00, fin.quo});
      end
      unique case (fin.mode)
         etc_pkg::MODE_SHAPE:
            raw = $signed({{19{fin.c0[15]}}, fin.c0, 4'b0000}) - $signed({q[Q_WIDTH-1], q});
         etc_pkg::MODE_PLATEAU:
            raw = $signed({{19{fin.c6[15]}}, fin.c6, 4'b0000});
         default:
            raw = $signed({23'd0, etc_pkg::ONE_Q14});
      endcase
      fac_in.nonpos = 1'b0;
      fac_in.sat    = 1'b0;
      priority if (raw <= 0) begin
         fac_in.factor = '0;
         fac_in.nonpos = 1'b1;
         fac_in.sat    = 1'b1;
      end else if (raw > $signed(RAW_WIDTH'(65535))) begin
         fac_in.factor = '1;
         fac_in.sat    = 1'b1;
      end else begin
         fac_in.factor = raw[etc_pkg::FACTOR_WIDTH-1:0];
      end
      fac_in.applied = (fac_in.factor != etc_pkg::ONE_Q14);
   end

   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else       out_valid_ff <= dv_valid_ff[QB];
   end
   always_ff @(posedge clock) begin
      out_payload_ff <= fin.payload;
      out_factor_ff  <= fac_in;
   end

   assign out_valid   = out_valid_ff;
   assign out_payload = out_payload_ff;
   assign out_factor  = out_factor_ff;

endmodule

// ===== hw/rtl/eta_transition_energy_correction.sv =====
// Top level: configuration registers, factor pipeline and per-energy pipelined dividers.
//
// Usage:
//   Input: drive the cluster item on the req_ ports and pulse start. An item is
//   taken on every clock edge with start high and busy low; busy never rises,
//   so one item per cycle is sustained with no gaps.
//   Output: each item yields exactly one result, shown on the rsp_ ports for a
//   single cycle with rsp_valid high. The receiver cannot stall, and the block
//   never needs it to: items leave in order, one per cycle at most.
//   Pipeline: each item passes two restoring dividers in series, with 36 bit
//   stages for the factor quotient and ENERGY_WIDTH+14 bit stages for the
//   energy quotients, plus the stages of exponent and table work, divider
//   setup, factor assembly and the output register.
//   Configuration: csr_ writes are always ready and take effect at once;
//   write only while no item is in flight. Unknown indexes are ignored.
//   Reset: synchronous, clears the configuration registers and every valid
//   bit, dropping any in-flight item; no clearing pass, the block takes items
//   the next cycle.
module eta_transition_energy_correction (
   input  logic                                       clock,
   input  logic                                       reset,
   // item input
   input  logic                                       start,
   output logic                                       busy,
   input  logic signed [etc_pkg::ETA_WIDTH-1:0]       req_raw_eta,
   input  logic signed [etc_pkg::ETA_WIDTH-1:0]       req_adjusted_eta,
   input  logic signed [etc_pkg::ENERGY_WIDTH-1:0]    req_total_energy,
   input  logic signed [etc_pkg::ENERGY_WIDTH-1:0]    req_barrel_strip_energy,
   input  logic signed [etc_pkg::ENERGY_WIDTH-1:0]    req_barrel_middle_energy,
   input  logic signed [etc_pkg::ENERGY_WIDTH-1:0]    req_barrel_back_energy,
   input  logic signed [etc_pkg::ENERGY_WIDTH-1:0]    req_endcap_strip_energy,
   input  logic signed [etc_pkg::ENERGY_WIDTH-1:0]    req_endcap_middle_energy,
   input  logic signed [etc_pkg::ENERGY_WIDTH-1:0]    req_endcap_back_energy,
   input  logic [etc_pkg::NUM_LAYERS-1:0]             req_layer_present_mask,
   // result output
   output logic                                       rsp_valid,
   output logic signed [etc_pkg::ENERGY_WIDTH-1:0]    rsp_corrected_total,
   output logic signed [etc_pkg::ENERGY_WIDTH-1:0]    rsp_out_barrel_strip,
   output logic signed [etc_pkg::ENERGY_WIDTH-1:0]    rsp_out_barrel_middle,
   output logic signed [etc_pkg::ENERGY_WIDTH-1:0]    rsp_out_barrel_back,
   output logic signed [etc_pkg::ENERGY_WIDTH-1:0]    rsp_out_endcap_strip,
   output logic signed [etc_pkg::ENERGY_WIDTH-1:0]    rsp_out_endcap_middle,
   output logic signed [etc_pkg::ENERGY_WIDTH-1:0]    rsp_out_endcap_back,
   output logic [etc_pkg::FACTOR_WIDTH-1:0]           rsp_correction_factor,
   output logic                                       rsp_correction_applied,
   output logic                                       rsp_saturated,
   // configuration
   input  logic                                       csr_valid,
   output logic                                       csr_ready,
   input  logic [etc_pkg::CSR_INDEX_WIDTH-1:0]        csr_index,
   input  logic [etc_pkg::CSR_DATA_WIDTH-1:0]         csr_wdata
);

   localparam int EW  = etc_pkg::ENERGY_WIDTH;
   localparam int EQB = etc_pkg::EDIV_BITS;
   localparam int NE  = etc_pkg::NUM_ENERGIES;

   localparam logic [EW-1:0]  EMAX     = {1'b0, {(EW-1){1'b1}}};
   localparam logic [EW-1:0]  EMIN     = {1'b1, {(EW-1){1'b0}}};
   localparam logic [EQB-1:0] EMAX_MAG = EQB'(EMAX);
   localparam logic [EQB-1:0] EMIN_MAG = EQB'(EMIN);

   // one energy lane of the restoring divider
   typedef struct packed {
      logic [EQB-1:0] num;
      logic [15:0]    rem;
      logic [EQB-1:0] quo;
      logic           neg;
      logic           divide;
      logic [EW-1:0]  orig;
   } lane_type;

   function automatic lane_type lane_step(input lane_type s,
                                          input logic [etc_pkg::FACTOR_WIDTH-1:0] f);
      lane_type    r;
      logic [16:0] rem2;
      logic        ge;
      r     = s;
      rem2  = {s.rem, s.num[EQB-1]};
      ge    = (rem2 >= {1'b0, f});
      r.rem = ge ? 16'(rem2 - {1'b0, f}) : rem2[15:0];
      r.num = {s.num[EQB-2:0], 1'b0};
      r.quo = {s.quo[EQB-2:0], ge};
      return r;
   endfunction

   // ---------------- configuration registers ----------------
   etc_pkg::cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (etc_pkg::csr_index_type'(csr_index))
            etc_pkg::CSR_USE_ADJUSTED_ETA:    cfg_in.use_adjusted_eta    = csr_wdata[0];
            etc_pkg::CSR_ZERO_WINDOW:         cfg_in.zero_window         = csr_wdata[31:0];
            etc_pkg::CSR_EIGHT_WINDOW:        cfg_in.eight_window        = csr_wdata[31:0];
            etc_pkg::CSR_ZERO_COEFFS_FIRST:   cfg_in.zero_coeffs_first   = csr_wdata;
            etc_pkg::CSR_ZERO_COEFFS_SECOND:  cfg_in.zero_coeffs_second  = csr_wdata[47:0];
            etc_pkg::CSR_EIGHT_COEFFS_FIRST:  cfg_in.eight_coeffs_first  = csr_wdata;
            etc_pkg::CSR_EIGHT_COEFFS_SECOND: cfg_in.eight_coeffs_second = csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) cfg_ff <= '0;
      else       cfg_ff <= cfg_in;
   end

   // ---------------- factor pipeline ----------------
   // never stalls, so an item is always taken
   assign busy = 1'b0;

   etc_pkg::payload_type in_payload, fac_payload;
   etc_pkg::factor_type  fac;
   logic                 fac_valid;

   always_comb begin
      in_payload.energy[0] = req_total_energy;
      in_payload.energy[1] = req_barrel_strip_energy;
      in_payload.energy[2] = req_barrel_middle_energy;
      in_payload.energy[3] = req_barrel_back_energy;
      in_payload.energy[4] = req_endcap_strip_energy;
      in_payload.energy[5] = req_endcap_middle_energy;
      in_payload.energy[6] = req_endcap_back_energy;
      in_payload.mask      = req_layer_present_mask;
   end

   etc_factor u_factor (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (start & ~busy),
      .in_raw_eta      (req_raw_eta),
      .in_adjusted_eta (req_adjusted_eta),
      .in_payload      (in_payload),
      .cfg             (cfg_ff),
      .out_valid       (fac_valid),
      .out_payload     (fac_payload),
      .out_factor      (fac)
   );

   // ---------------- energy dividers: E * 2^14 / f ----------------
   logic                ev_ff [EQB+1];
   etc_pkg::factor_type ef_ff [EQB+1];
   lane_type            lane_ff [NE][EQB+1];
   lane_type            lane_in [NE];
   logic [EW-1:0]       e_cur [NE];

   always_comb begin
      for (int i = 0; i < NE; i++) begin
         e_cur[i]          = fac_payload.energy[i];
         lane_in[i].neg    = e_cur[i][EW-1];
         lane_in[i].num    = {(e_cur[i][EW-1] ? EW'(-e_cur[i]) : e_cur[i]),
                              {etc_pkg::Q14_SHIFT{1'b0}}};
         lane_in[i].rem    = '0;
         lane_in[i].quo    = '0;
         lane_in[i].orig   = e_cur[i];
         // when the factor is applied, the total divides; layers only when present
         lane_in[i].divide = fac.applied && ((i == 0) || fac_payload.mask[(i == 0) ? 0 : i - 1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) ev_ff[0] <= 1'b0;
      else       ev_ff[0] <= fac_valid;
   end
   always_ff @(posedge clock) begin
      ef_ff[0] <= fac;
   end
   for (genvar i = 0; i < NE; i++) begin : g_lane_load
      always_ff @(posedge clock) begin
         lane_ff[i][0] <= lane_in[i];
      end
   end

   for (genvar s = 1; s <= EQB; s++) begin : g_ediv
      always_ff @(posedge clock) begin
         if (reset) ev_ff[s] <= 1'b0;
         else       ev_ff[s] <= ev_ff[s-1];
      end
      always_ff @(posedge clock) begin
         ef_ff[s] <= ef_ff[s-1];
      end
      for (genvar i = 0; i < NE; i++) begin : g_lane
         always_ff @(posedge clock) begin
            lane_ff[i][s] <= lane_step(lane_ff[i][s-1], ef_ff[s-1].factor);
         end
      end
   end

   // ---------------- result: sign, saturation, output register ----------------
   logic [EW-1:0]    res_in [NE];
   logic [NE-1:0]    lane_sat;
   lane_type         fl [NE];
   logic             rsp_valid_ff;
   logic [EW-1:0]    res_ff [NE];
   logic [etc_pkg::FACTOR_WIDTH-1:0] factor_ff;
   logic             applied_ff, sat_ff;

   always_comb begin
      for (int i = 0; i < NE; i++) begin
         fl[i]       = lane_ff[i][EQB];
         lane_sat[i] = 1'b0;
         if (!fl[i].divide) begin
            res_in[i] = fl[i].orig;
         end else if (ef_ff[EQB].nonpos) begin
            if (fl[i].neg)               res_in[i] = EMIN;
            else if (fl[i].orig != '0)   res_in[i] = EMAX;
            else                         res_in[i] = '0;
         end else if (!fl[i].neg) begin
            if (fl[i].quo > EMAX_MAG) begin
               res_in[i]   = EMAX;
               lane_sat[i] = 1'b1;
            end else begin
               res_in[i] = fl[i].quo[EW-1:0];
            end
         end else begin
            if (fl[i].quo > EMIN_MAG) begin
               res_in[i]   = EMIN;
               lane_sat[i] = 1'b1;
            end else begin
               res_in[i] = EW'(EQB'(0) - fl[i].quo);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= ev_ff[EQB];
   end
   always_ff @(posedge clock) begin
      for (int i = 0; i < NE; i++) res_ff[i] <= res_in[i];
      factor_ff  <= ef_ff[EQB].factor;
      applied_ff <= ef_ff[EQB].applied;
      sat_ff     <= ef_ff[EQB].sat | (|lane_sat);
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_corrected_total    = res_ff[0];
   assign rsp_out_barrel_strip   = res_ff[1];
   assign rsp_out_barrel_middle  = res_ff[2];
   assign rsp_out_barrel_back    = res_ff[3];
   assign rsp_out_endcap_strip   = res_ff[4];
   assign rsp_out_endcap_middle  = res_ff[5];
   assign rsp_out_endcap_back    = res_ff[6];
   assign rsp_correction_factor  = factor_ff;
   assign rsp_correction_applied = applied_ff;
   assign rsp_saturated          = sat_ff;

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the transition-region energy correction block.
`timescale 1ns / 1ps

module testbench;

   localparam int EW          = etc_pkg::ENERGY_WIDTH;
   localparam int NE          = etc_pkg::NUM_ENERGIES;
   localparam int NL          = etc_pkg::NUM_LAYERS;
   localparam int TSIZE       = etc_pkg::TABLE_SIZE;
   localparam int FSHIFT      = etc_pkg::FRAC_SHIFT;
   localparam int LATENCY     = 94;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic signed [63:0] E_MAX = (64'sd1 <<< (EW - 1)) - 1;
   localparam logic signed [63:0] E_MIN = -E_MAX - 1;

   // one cluster item as the block sees it
   typedef struct {
      logic signed [15:0] raw_eta;
      logic signed [15:0] adj_eta;
      logic signed [EW-1:0] energy [NE];
      logic [NL-1:0] mask;
   } cluster_type;

   // expected corrected cluster
   typedef struct {
      logic [EW-1:0] energy [NE];
      logic [15:0] factor;
      logic applied;
      logic sat;
   } corrected_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [15:0] req_raw_eta = '0, req_adjusted_eta = '0;
   logic signed [EW-1:0] req_e [NE];
   logic [NL-1:0] req_layer_present_mask = '0;
   logic rsp_valid;
   logic signed [EW-1:0] rsp_e [NE];
   logic [15:0] rsp_correction_factor;
   logic rsp_correction_applied, rsp_saturated;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [etc_pkg::CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [63:0] csr_wdata = '0;

   initial for (int i = 0; i < NE; i++) req_e[i] = '0;

   eta_transition_energy_correction dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_raw_eta(req_raw_eta), .req_adjusted_eta(req_adjusted_eta),
      .req_total_energy(req_e[0]),
      .req_barrel_strip_energy(req_e[1]), .req_barrel_middle_energy(req_e[2]),
      .req_barrel_back_energy(req_e[3]), .req_endcap_strip_energy(req_e[4]),
      .req_endcap_middle_energy(req_e[5]), .req_endcap_back_energy(req_e[6]),
      .req_layer_present_mask(req_layer_present_mask),
      .rsp_valid(rsp_valid), .rsp_corrected_total(rsp_e[0]),
      .rsp_out_barrel_strip(rsp_e[1]), .rsp_out_barrel_middle(rsp_e[2]),
      .rsp_out_barrel_back(rsp_e[3]), .rsp_out_endcap_strip(rsp_e[4]),
      .rsp_out_endcap_middle(rsp_e[5]), .rsp_out_endcap_back(rsp_e[6]),
      .rsp_correction_factor(rsp_correction_factor),
      .rsp_correction_applied(rsp_correction_applied), .rsp_saturated(rsp_saturated),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Our copy of the register file and the 2^x table.
   logic        cfg_adj;
   logic [31:0] cfg_zwin, cfg_ewin;
   logic [63:0] cfg_zc1, cfg_ec1;
   logic [47:0] cfg_zc2;
   logic [31:0] cfg_ec2;
   longint      pow2_q16 [TSIZE];

   corrected_type expected_q [$];
   int            mismatches = 0;
   longint        cycles = 0;

   function automatic void fill_pow2();
      longint unsigned u, term, sum;
      for (int i = 0; i < TSIZE; i++) begin
         u = (64'(i) * 64'd744261118) >> etc_pkg::EXP_TABLE_BITS;
         term = 64'd1 << 30;
         sum = term;
         for (int k = 1; k <= 12; k++) begin
            term = ((term * u) >> 30) / 64'(k);
            sum += term;
         end
         pow2_q16[i] = longint'((sum + 64'd8192) >> 14);
      end
   endfunction

   function automatic longint coef(logic [63:0] r, int k);
      return longint'($signed(r[16*k +: 16]));
   endfunction

   // arithmetic right shift of a signed value is a floor shift
   function automatic longint exp_q16(longint x);
      longint y, fr, n, lo, hi, m, idx, rem;
      y = (x * 5909) >>> 12;
      fr = y & 4095;
      n = (y - fr) / 4096;
      if (n > 23) return longint'(1) << 40;
      if (n < -20) return 0;
      idx = fr >> FSHIFT;
      rem = fr & ((1 << FSHIFT) - 1);
      lo = pow2_q16[idx];
      hi = pow2_q16[idx + 1];
      m = lo + (((hi - lo) * rem) >>> FSHIFT);
      return (n >= 0) ? (m << n) : (m >> (-n));
   endfunction

   function automatic longint shape_factor(longint a, logic [63:0] c1st, logic [63:0] c2nd);
      longint c0, c1, c2, c3, c4, c5, x1, x2, d, q;
      c0 = coef(c1st, 0); c1 = coef(c1st, 1); c2 = coef(c1st, 2); c3 = coef(c1st, 3);
      c4 = coef(c2nd, 0); c5 = coef(c2nd, 1);
      x1 = c2 * 4 - a;
      x2 = (c3 * (a - c4 * 4)) >>> 10;
      d = exp_q16(x1) + exp_q16(x2) + c5 * 64;
      if (d == 0) q = (c1 > 0) ? (longint'(1) << 36) : ((c1 < 0) ? -(longint'(1) << 36) : 0);
      else q = (c1 * 1048576) / d;
      return c0 * 16 - q;
   endfunction

   function automatic corrected_type correct_cluster(cluster_type c);
      corrected_type r;
      longint eta, a, raw, f, e, q, zlo, zhi, elo, ehi;
      bit nonpos;
      eta = cfg_adj ? longint'(c.adj_eta) : longint'(c.raw_eta);
      a = eta < 0 ? -eta : eta;
      zlo = longint'(cfg_zwin[15:0]); zhi = longint'(cfg_zwin[31:16]);
      elo = longint'(cfg_ewin[15:0]); ehi = longint'(cfg_ewin[31:16]);
      raw = 16384;
      nonpos = 1'b0;
      r.sat = 1'b0;
      if (a < zhi && a > zlo) raw = shape_factor(a, cfg_zc1, {16'd0, cfg_zc2});
      else if (a < zlo) raw = coef({16'd0, cfg_zc2}, 2) * 16;
      if (a < ehi && a > elo) raw = shape_factor(a, cfg_ec1, {32'd0, cfg_ec2});
      if (raw <= 0) begin
         f = 0; nonpos = 1'b1; r.sat = 1'b1;
      end else if (raw > 65535) begin
         f = 65535; r.sat = 1'b1;
      end else begin
         f = raw;
      end
      r.applied = (f != 16384);
      r.factor = f[15:0];
      for (int i = 0; i < NE; i++) begin
         e = longint'(c.energy[i]);
         q = e;
         if (r.applied && (i == 0 || c.mask[i-1])) begin
            if (nonpos) q = (e > 0) ? E_MAX : ((e < 0) ? E_MIN : 0);
            else begin
               q = (e * 16384) / f;
               if (q > E_MAX) begin q = E_MAX; r.sat = 1'b1; end
               if (q < E_MIN) begin q = E_MIN; r.sat = 1'b1; end
            end
         end
         r.energy[i] = q[EW-1:0];
      end
      return r;
   endfunction

   // Result checker: every strobe must match the oldest expectation.
   always @(posedge clock) begin
      corrected_type x;
      bit bad;
      cycles <= cycles + 1;
      if (!reset && rsp_valid) begin
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result at cycle %0d", cycles);
         end else begin
            x = expected_q.pop_front();
            bad = (rsp_correction_factor !== x.factor) ||
                  (rsp_correction_applied !== x.applied) || (rsp_saturated !== x.sat);
            for (int i = 0; i < NE; i++)
               if (rsp_e[i] !== x.energy[i]) bad = 1'b1;
            if (bad) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch: factor exp %0d got %0d, applied exp %0b got %0b, sat exp %0b got %0b",
                           x.factor, rsp_correction_factor, x.applied, rsp_correction_applied,
                           x.sat, rsp_saturated);
                  for (int i = 0; i < NE; i++)
                     $display("  energy[%0d] exp %0d got %0d", i,
                              $signed(x.energy[i]), rsp_e[i]);
               end
            end
         end
      end
   end

   // Timeout watchdog.
   always @(posedge clock) begin
      if (cycles > CYCLE_LIMIT) begin
         $display("** eta_transition_energy_correction: FAILED **");
         $finish;
      end
   end

   // csr_valid stays high across back-to-back writes; the caller drops it
   task automatic write_csr(etc_pkg::csr_index_type idx, logic [63:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         etc_pkg::CSR_USE_ADJUSTED_ETA:    cfg_adj  = val[0];
         etc_pkg::CSR_ZERO_WINDOW:         cfg_zwin = val[31:0];
         etc_pkg::CSR_EIGHT_WINDOW:        cfg_ewin = val[31:0];
         etc_pkg::CSR_ZERO_COEFFS_FIRST:   cfg_zc1  = val;
         etc_pkg::CSR_ZERO_COEFFS_SECOND:  cfg_zc2  = val[47:0];
         etc_pkg::CSR_EIGHT_COEFFS_FIRST:  cfg_ec1  = val;
         etc_pkg::CSR_EIGHT_COEFFS_SECOND: cfg_ec2  = val[31:0];
         default: ;
      endcase
   endtask

   task automatic set_all(logic adj, logic [31:0] zw, logic [31:0] ew, logic [63:0] zc1,
                          logic [47:0] zc2, logic [63:0] ec1, logic [31:0] ec2);
      write_csr(etc_pkg::CSR_USE_ADJUSTED_ETA, {63'd0, adj});
      write_csr(etc_pkg::CSR_ZERO_WINDOW, {32'd0, zw});
      write_csr(etc_pkg::CSR_EIGHT_WINDOW, {32'd0, ew});
      write_csr(etc_pkg::CSR_ZERO_COEFFS_FIRST, zc1);
      write_csr(etc_pkg::CSR_ZERO_COEFFS_SECOND, {16'd0, zc2});
      write_csr(etc_pkg::CSR_EIGHT_COEFFS_FIRST, ec1);
      write_csr(etc_pkg::CSR_EIGHT_COEFFS_SECOND, {32'd0, ec2});
      csr_valid <= 1'b0;
   endtask

   // Send one item; start stays high across back-to-back items.
   task automatic send_item(cluster_type c, int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_raw_eta <= c.raw_eta;
      req_adjusted_eta <= c.adj_eta;
      for (int i = 0; i < NE; i++) req_e[i] <= c.energy[i];
      req_layer_present_mask <= c.mask;
      do @(posedge clock); while (busy);
      expected_q.push_back(correct_cluster(c));
   endtask

   task automatic drain();
      start <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic cluster_type rand_cluster(int eta_span);
      cluster_type c;
      int sel;
      c.raw_eta = (eta_span > 0) ? 16'($urandom_range(0, 2 * eta_span) - eta_span) : 16'($urandom);
      c.adj_eta = (eta_span > 0) ? 16'($urandom_range(0, 2 * eta_span) - eta_span) : 16'($urandom);
      for (int i = 0; i < NE; i++) begin
         sel = $urandom_range(0, 9);
         if (sel == 0) c.energy[i] = 32'h7fffffff;
         else if (sel == 1) c.energy[i] = 32'h80000000;
         else if (sel == 2) c.energy[i] = 0;
         else if (sel < 6) c.energy[i] = $urandom_range(0, 2000000) - 1000000;
         else c.energy[i] = $urandom;
      end
      c.mask = NL'($urandom);
      return c;
   endfunction

   function automatic int rand_gap();
      return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 10) : 0;
   endfunction

   // Realistic-ish coefficient set: c0 near 1, modest exponents.
   function automatic logic [63:0] rand_coeffs_first();
      logic [15:0] c0, c1, c2, c3;
      c0 = 16'($urandom_range(900, 1200));
      c1 = 16'($urandom_range(0, 600) - 300);
      c2 = 16'($urandom_range(0, 8000) - 4000);
      c3 = 16'($urandom_range(0, 16000) - 8000);
      return {c3, c2, c1, c0};
   endfunction

   task automatic test_directed();
      cluster_type c;
      // shape in zero window, plateau below it, 0.8 window overriding
      set_all(1'b0, {16'd4000, 16'd100}, {16'd3800, 16'd3000},
              {16'd2048, 16'd0, 16'd100, 16'd1000}, {16'd1100, 16'd0, 16'd50},
              {16'd1024, 16'd2048, 16'd300, 16'd1100}, {16'd1, 16'd3000});
      foreach (c.energy[i]) c.energy[i] = 1000 * (i + 1);
      c.mask = 6'b101010;
      c.adj_eta = 16'sd0;
      c.raw_eta = 16'sd0;      send_item(c, 0);   // below zero window: plateau
      c.raw_eta = 16'sd100;    send_item(c, 0);   // on lower edge: factor one
      c.raw_eta = -16'sd2000;  send_item(c, 0);   // inside zero window
      c.raw_eta = 16'sd3500;   send_item(c, 0);   // overlap, 0.8 window wins
      c.raw_eta = 16'sh7fff;   send_item(c, 1);   // above everything
      c.raw_eta = 16'sh8000;   send_item(c, 0);   // most negative eta
      c.mask = 6'b111111;
      foreach (c.energy[i]) c.energy[i] = (i % 2) ? 32'h7fffffff : 32'h80000000;
      c.raw_eta = 16'sd0;      send_item(c, 0);   // plateau 1100, all layers at full scale
      c.mask = 6'b000000;
      c.raw_eta = 16'sd2000;   send_item(c, 2);
      drain();
      // non-positive factor: negative plateau at two eta values
      set_all(1'b1, {16'd0, 16'hffff}, {16'd0, 16'd0}, 64'd0, {16'hfc00, 16'd0, 16'd0},
              64'd0, 32'd0);
      foreach (c.energy[i]) c.energy[i] = (i == 3) ? 0 : ((i % 2) ? 5 : -5);
      c.mask = 6'b110011;
      c.adj_eta = 16'sd10;     send_item(c, 0);
      c.adj_eta = -16'sd1;     send_item(c, 0);
      drain();
      // large negative exponents and large c1 of both signs
      set_all(1'b0, {16'hffff, 16'd0}, {16'd0, 16'd0},
              {16'd0, 16'h8000, 16'h7fff, 16'h4000}, {16'd0, 16'd0, 16'd0}, 64'd0, 32'd0);
      c.raw_eta = 16'sd20000;  send_item(c, 0);
      drain();
      set_all(1'b0, {16'hffff, 16'd0}, {16'd0, 16'd0},
              {16'd0, 16'h8000, 16'h8000, 16'h7fff}, {16'd0, 16'd0, 16'd0}, 64'd0, 32'd0);
      c.raw_eta = 16'sd20000;  send_item(c, 0);   // exp underflow, factor clamps high
      c.raw_eta = 16'sd5;      send_item(c, 0);
      drain();
      // factor above range: plateau max
      set_all(1'b0, {16'hffff, 16'hffff}, {16'hffff, 16'hffff}, 64'hffff_ffff_ffff_ffff,
              48'h7fff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 32'hffff_ffff);
      c.raw_eta = 16'sd3;      send_item(c, 0);
      c.raw_eta = 16'sh7fff;   send_item(c, 0);
      drain();
   endtask

   task automatic test_random();
      cluster_type c;
      logic [15:0] zl, zh, el, eh;
      for (int phase = 0; phase < 9; phase++) begin
         zl = 16'($urandom_range(0, 3000)); zh = 16'(zl + $urandom_range(0, 6000));
         el = 16'($urandom_range(0, 5000)); eh = 16'(el + $urandom_range(0, 4000));
         if (phase == 8) begin zl = 16'hffff; zh = 16'hffff; el = 16'hffff; eh = '0; end
         set_all(1'($urandom_range(0, 1)), {zh, zl}, {eh, el}, rand_coeffs_first(),
                 (phase == 7) ? 48'($urandom) << 16 | 48'($urandom) :
                 {16'($urandom_range(800, 1300)), 16'($urandom_range(0, 200) - 100),
                  16'($urandom_range(0, 6000))},
                 (phase == 6) ? {$urandom, $urandom} : rand_coeffs_first(),
                 {16'($urandom_range(0, 200) - 100), 16'($urandom_range(0, 6000))});
         for (int n = 0; n < 105; n++) begin
            c = rand_cluster(($urandom_range(0, 3) == 0) ? 0 : 12000);
            send_item(c, rand_gap());
         end
         drain();
      end
   endtask

   initial begin
      fill_pow2();
      cfg_adj = 1'b0; cfg_zwin = '0; cfg_ewin = '0; cfg_zc1 = '0; cfg_zc2 = '0;
      cfg_ec1 = '0; cfg_ec2 = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random();
      // nothing expected now; allow the pipeline to show strays
      repeat (LATENCY + 20) @(posedge clock);
      if (mismatches == 0 && expected_q.size() == 0)
         $display("** eta_transition_energy_correction: PASSED **");
      else
         $display("** eta_transition_energy_correction: FAILED **");
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/etc_pkg.sv
hw/rtl/etc_factor.sv
hw/rtl/eta_transition_energy_correction.sv
verif/testbench.sv
